### sv/osfc_pkg.sv
// Shared types, operand codes and the step program of the observer controller.
package osfc_pkg;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_W    = 64;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned MS_PER_S = 1000;
  localparam int unsigned REM_W    = 10;
  localparam int unsigned PC_W     = 6;

  typedef enum logic [2:0] {
    OP_CLR,
    OP_LDY,
    OP_LDV,
    OP_MAC,
    OP_ST,
    OP_END
  } op_kind_t;

  typedef logic [4:0] opnd_t;

  // Coefficient halves: register i upper half is 2*i, lower half 2*i+1.
  localparam opnd_t C_K0  = 5'd0;
  localparam opnd_t C_K1  = 5'd1;
  localparam opnd_t C_K2  = 5'd2;
  localparam opnd_t C_A00 = 5'd4;
  localparam opnd_t C_A01 = 5'd5;
  localparam opnd_t C_A10 = 5'd6;
  localparam opnd_t C_A11 = 5'd7;
  localparam opnd_t C_B0  = 5'd8;
  localparam opnd_t C_B1  = 5'd9;
  localparam opnd_t C_B2  = 5'd10;
  localparam opnd_t C_SP  = 5'd11;
  localparam opnd_t C_C0  = 5'd12;
  localparam opnd_t C_C1  = 5'd13;
  localparam opnd_t C_L0  = 5'd14;
  localparam opnd_t C_L1  = 5'd15;
  // Working variables.
  localparam opnd_t V_X0  = 5'd16;
  localparam opnd_t V_X1  = 5'd17;
  localparam opnd_t V_X2  = 5'd18;
  localparam opnd_t V_U   = 5'd19;
  localparam opnd_t V_E   = 5'd20;
  localparam opnd_t V_D   = 5'd21;
  localparam opnd_t V_H   = 5'd22;

  typedef struct packed {
    op_kind_t kind;
    opnd_t    a;
    opnd_t    b;
    logic     neg;
  } uop_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // u, e, then the three estimate updates, each through the shared multiplier.
  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t r;
    unique case (pc)
      6'd0:  r = '{OP_CLR, C_K0,  V_X0, 1'b0};
      6'd1:  r = '{OP_MAC, C_K0,  V_X0, 1'b1};
      6'd2:  r = '{OP_MAC, C_K1,  V_X1, 1'b1};
      6'd3:  r = '{OP_MAC, C_K2,  V_X2, 1'b1};
      6'd4:  r = '{OP_ST,  C_K0,  V_U,  1'b0};
      6'd5:  r = '{OP_LDY, C_SP,  V_X0, 1'b0};
      6'd6:  r = '{OP_MAC, C_C0,  V_X0, 1'b1};
      6'd7:  r = '{OP_MAC, C_C1,  V_X1, 1'b1};
      6'd8:  r = '{OP_ST,  C_K0,  V_E,  1'b0};
      6'd9:  r = '{OP_CLR, C_K0,  V_X0, 1'b0};
      6'd10: r = '{OP_MAC, C_A00, V_X0, 1'b0};
      6'd11: r = '{OP_MAC, C_A01, V_X1, 1'b0};
      6'd12: r = '{OP_MAC, C_B0,  V_U,  1'b0};
      6'd13: r = '{OP_MAC, C_L0,  V_E,  1'b0};
      6'd14: r = '{OP_ST,  C_K0,  V_D,  1'b0};
      6'd15: r = '{OP_LDV, C_K0,  V_X0, 1'b0};
      6'd16: r = '{OP_MAC, V_H,   V_D,  1'b0};
      6'd17: r = '{OP_ST,  C_K0,  V_X0, 1'b0};
      6'd18: r = '{OP_CLR, C_K0,  V_X0, 1'b0};
      6'd19: r = '{OP_MAC, C_A10, V_X0, 1'b0};
      6'd20: r = '{OP_MAC, C_A11, V_X1, 1'b0};
      6'd21: r = '{OP_MAC, C_B1,  V_U,  1'b0};
      6'd22: r = '{OP_MAC, C_L1,  V_E,  1'b0};
      6'd23: r = '{OP_ST,  C_K0,  V_D,  1'b0};
      6'd24: r = '{OP_LDV, C_K0,  V_X1, 1'b0};
      6'd25: r = '{OP_MAC, V_H,   V_D,  1'b0};
      6'd26: r = '{OP_ST,  C_K0,  V_X1, 1'b0};
      6'd27: r = '{OP_CLR, C_K0,  V_X0, 1'b0};
      6'd28: r = '{OP_MAC, C_B2,  V_U,  1'b0};
      6'd29: r = '{OP_ST,  C_K0,  V_D,  1'b0};
      6'd30: r = '{OP_LDV, C_K0,  V_X2, 1'b0};
      6'd31: r = '{OP_MAC, V_H,   V_D,  1'b0};
      6'd32: r = '{OP_ST,  C_K0,  V_X2, 1'b0};
      default: r = '{OP_END, C_K0, V_X0, 1'b0};
    endcase
    return r;
  endfunction

endpackage

### sv/osfc_smul.sv
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
module osfc_smul
  import osfc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     done,
  output logic signed [63:0]       prod
);

  logic signed [DATA_W:0]   hi_r;
  logic [DATA_W-1:0]        lo_r;
  logic [DATA_W-1:0]        a_r;
  logic signed [DATA_W-1:0] b_r;
  logic [4:0]               cnt_r;
  logic                     run_r;
  logic                     done_r;

  logic                     last;
  logic signed [DATA_W+1:0] addend;
  logic signed [DATA_W+1:0] sum;

  assign last = (cnt_r == 5'd31);

  always_comb begin
    addend = '0;
    if (a_r[0]) begin
      // sign bit of the multiplier carries negative weight
      addend = last ? -{{2{b_r[DATA_W-1]}}, b_r} : {{2{b_r[DATA_W-1]}}, b_r};
    end
    sum = {hi_r[DATA_W], hi_r} + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        hi_r  <= '0;
        a_r   <= a;
        b_r   <= b;
      end else if (run_r) begin
        hi_r  <= sum[DATA_W+1:1];
        lo_r  <= {sum[0], lo_r[DATA_W-1:1]};
        a_r   <= {1'b0, a_r[DATA_W-1:1]};
        cnt_r <= cnt_r + 5'd1;
        if (last) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = {hi_r[DATA_W-1:0], lo_r};

endmodule

### sv/observer_state_feedback_controller.sv
// Observer-based state feedback controller: sequencer, register file and time step divider.
// An init word (in_tuser low) clears the estimates and records its time. A step word runs
//   a restoring division of the time step over 32 + FRAC_BITS dividend bits, then 17 products
//   on the one bit-serial multiplier, along with the other program steps.
// Throughput: one word at a time; a finished result waits in the output register.
// Reset: synchronous active-low rst_n clears registers, estimates and previous time to zero.
module observer_state_feedback_controller
  import osfc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // angle [31:0], time_ms [63:32]
  input  logic             in_tuser,   // action
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // motor_speed [31:0]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  localparam int unsigned DIV_W = DATA_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(DIV_W);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_RUN, S_MUL, S_DONE} state_t;

  state_t                   state_r;
  logic [REG_W-1:0]         regs_r [NUM_REGS];
  logic signed [DATA_W-1:0] x0_r, x1_r, x2_r, u_r, e_r, d_r, h_r, y_r;
  logic [DATA_W-1:0]        prev_r;
  logic signed [63:0]       acc_r;
  logic [PC_W-1:0]          pc_r;
  logic [DIV_W-1:0]         dv_r;
  logic [REM_W-1:0]         rem_r;
  logic [DATA_W-2:0]        q_r;
  logic                     ovf_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_data_r;

  uop_t                     uop;
  logic signed [DATA_W-1:0] opa, opb;
  logic signed [DATA_W-1:0] acc_sat;
  logic                     mul_start, mul_done;
  logic signed [63:0]       mul_prod, prod_sh;
  logic [REM_W:0]           rem_t;
  logic                     qbit;
  logic [REM_W-1:0]         rem_nxt;
  logic [DATA_W-2:0]        q_nxt;
  logic                     ovf_nxt;
  logic                     in_acc;

  function automatic logic signed [DATA_W-1:0] opnd(
    input opnd_t c,
    input logic [REG_W-1:0] rg [NUM_REGS],
    input logic signed [DATA_W-1:0] x0, x1, x2, u, e, d, h
  );
    logic signed [DATA_W-1:0] r;
    r = '0;
    if (!c[4]) begin
      r = c[0] ? rg[c[3:1]][DATA_W-1:0] : rg[c[3:1]][REG_W-1:DATA_W];
    end else begin
      case (c)
        V_X0:    r = x0;
        V_X1:    r = x1;
        V_X2:    r = x2;
        V_U:     r = u;
        V_E:     r = e;
        V_D:     r = d;
        V_H:     r = h;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  assign uop     = prog(pc_r);
  assign opa     = opnd(uop.a, regs_r, x0_r, x1_r, x2_r, u_r, e_r, d_r, h_r);
  assign opb     = opnd(uop.b, regs_r, x0_r, x1_r, x2_r, u_r, e_r, d_r, h_r);
  assign acc_sat = sat32(acc_r);
  assign prod_sh = mul_prod >>> FRAC_BITS;

  assign mul_start = (state_r == S_RUN) && (uop.kind == OP_MAC);

  osfc_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // restoring division of dt * 2^FRAC_BITS by 1000, one quotient bit a cycle
  always_comb begin
    rem_t   = {rem_r, dv_r[DIV_W-1]};
    qbit    = (rem_t >= (REM_W+1)'(MS_PER_S));
    rem_nxt = qbit ? REM_W'(rem_t - (REM_W+1)'(MS_PER_S)) : rem_t[REM_W-1:0];
    q_nxt   = {q_r[DATA_W-3:0], qbit};
    ovf_nxt = ovf_r | q_r[DATA_W-2];
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
      x0_r        <= '0;
      x1_r        <= '0;
      x2_r        <= '0;
      prev_r      <= '0;
      pc_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        regs_r[cfg_index] <= cfg_data;
      end
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            prev_r <= in_tdata[63:32];
            if (!in_tuser) begin
              x0_r <= '0;
              x1_r <= '0;
              x2_r <= '0;
            end else begin
              y_r     <= in_tdata[31:0];
              dv_r    <= {in_tdata[63:32] - prev_r, {FRAC_BITS{1'b0}}};
              rem_r   <= '0;
              q_r     <= '0;
              ovf_r   <= 1'b0;
              cnt_r   <= CNT_W'(DIV_W - 1);
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dv_r  <= {dv_r[DIV_W-2:0], 1'b0};
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          ovf_r <= ovf_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            h_r     <= ovf_nxt ? 32'sh7fff_ffff : {1'b0, q_nxt};
            pc_r    <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          // hold the program counter while a product runs or at the end
          if ((uop.kind != OP_MAC) && (uop.kind != OP_END)) begin
            pc_r <= pc_r + PC_W'(1);
          end
          case (uop.kind)
            OP_CLR: acc_r <= '0;
            OP_LDY: acc_r <= 64'(y_r) - 64'(opa);
            OP_LDV: acc_r <= 64'(opb);
            OP_MAC: begin
              state_r <= S_MUL;
            end
            OP_ST: begin
              case (uop.b)
                V_X0:    x0_r <= acc_sat;
                V_X1:    x1_r <= acc_sat;
                V_X2:    x2_r <= acc_sat;
                V_U:     u_r  <= acc_sat;
                V_E:     e_r  <= acc_sat;
                default: d_r  <= acc_sat;
              endcase
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          if (mul_done) begin
            acc_r   <= uop.neg ? acc_r - prod_sh : acc_r + prod_sh;
            pc_r    <= pc_r + PC_W'(1);
            state_r <= S_RUN;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= u_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
